// File: design/pgcb_pkg.sv
// Shared types, constants and microcode definitions for the GPO command builder.
package pgcb_pkg;

    // Default buffer capacity in bytes
    localparam int DATA_MAX_DEF = 64;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TXN_QUAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMOUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTRY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENCY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TXN_DATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TXN_TYPE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNPRED_NUM = 3'd6;

    // Terminal data reset values
    localparam logic [31:0] RST_TXN_QUAL   = 32'hE000_C800;
    localparam logic [47:0] RST_AMOUNT     = 48'h0000_0000_0001;
    localparam logic [15:0] RST_COUNTRY    = 16'h0840;
    localparam logic [15:0] RST_CURRENCY   = 16'h0840;
    localparam logic [23:0] RST_TXN_DATE   = 24'h24_0417;
    localparam logic [7:0]  RST_TXN_TYPE   = 8'h00;
    localparam logic [31:0] RST_UNPRED_NUM = 32'h1234_5678;

    // Tag bytes
    localparam logic [4:0] TAG_MULTI_MASK = 5'h1F;
    localparam logic [7:0] TAG_9F       = 8'h9F;
    localparam logic [7:0] TAG_5F       = 8'h5F;
    localparam logic [7:0] TAG2_TTQ     = 8'h66;
    localparam logic [7:0] TAG2_AMOUNT  = 8'h02;
    localparam logic [7:0] TAG2_COUNTRY = 8'h1A;
    localparam logic [7:0] TAG2_CURR    = 8'h2A;
    localparam logic [7:0] TAG2_UN      = 8'h37;
    localparam logic [7:0] TAG_DATE     = 8'h9A;
    localparam logic [7:0] TAG_TYPE     = 8'h9C;

    // Command header bytes
    localparam logic [7:0] CMD_CLA      = 8'h80;
    localparam logic [7:0] CMD_INS      = 8'hA8;
    localparam logic [7:0] CMD_P1P2     = 8'h00;
    localparam logic [7:0] CMD_TEMPLATE = 8'h83;
    localparam logic [7:0] CMD_LE       = 8'h00;

    // Byte positions in the command stream
    localparam int POS_CLA  = 0;
    localparam int POS_INS  = 1;
    localparam int POS_P1   = 2;
    localparam int POS_P2   = 3;
    localparam int POS_LC   = 4;
    localparam int POS_TMPL = 5;
    localparam int POS_LEN  = 6;
    localparam int POS_DATA = 7;

    // Datapath operations driven by the microcode
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_PARSE = 3'd1,
        OP_PUSH  = 3'd2,
        OP_RDSET = 3'd3,
        OP_EMIT  = 3'd4
    } dp_op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_ACCEPT   = 3'd1,
        C_FUNC     = 3'd2,
        C_FILLGO   = 3'd3,
        C_FILLLAST = 3'd4,
        C_OUTFREE  = 3'd5
    } cond_t;

    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE     = 3'd0;
    localparam step_t ST_DISPATCH = 3'd1;
    localparam step_t ST_PARSE    = 3'd2;
    localparam step_t ST_FILL     = 3'd3;
    localparam step_t ST_RDSET    = 3'd4;
    localparam step_t ST_EMIT     = 3'd5;

    // One control word of the program
    typedef struct packed {
        logic   in_ready;
        dp_op_t op;
        cond_t  cond;
        step_t  tgt_t;
        step_t  tgt_f;
    } uword_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic   accept;
        dp_op_t op;
    } dp_ctl_t;

    // Datapath to sequencer status
    typedef struct packed {
        logic func;
        logic fill_go;
        logic fill_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/pgcb_seq.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
module pgcb_seq
    import pgcb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_ctl_t  ctl
);

    // Program store
    function automatic uword_t rom_word(input step_t s);
        uword_t w;
        begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: C_ALWAYS,
                  tgt_t: ST_IDLE, tgt_f: ST_IDLE};
            unique case (s)
                ST_IDLE:     w = '{1'b1, OP_NOP,   C_ACCEPT,   ST_DISPATCH, ST_IDLE};
                ST_DISPATCH: w = '{1'b0, OP_NOP,   C_FUNC,     ST_RDSET,    ST_PARSE};
                ST_PARSE:    w = '{1'b0, OP_PARSE, C_FILLGO,   ST_FILL,     ST_IDLE};
                ST_FILL:     w = '{1'b0, OP_PUSH,  C_FILLLAST, ST_IDLE,     ST_FILL};
                ST_RDSET:    w = '{1'b0, OP_RDSET, C_ALWAYS,   ST_EMIT,     ST_EMIT};
                ST_EMIT:     w = '{1'b0, OP_EMIT,  C_OUTFREE,  ST_IDLE,     ST_EMIT};
                default:     w = '{1'b0, OP_NOP,   C_ALWAYS,   ST_IDLE,     ST_IDLE};
            endcase
            rom_word = w;
        end
    endfunction

    step_t  step_reg, step_next;
    uword_t uw;
    logic   cond_hit;

    assign uw       = rom_word(step_reg);
    assign s_tready = uw.in_ready;
    assign ctl.accept = s_tvalid & uw.in_ready;
    assign ctl.op     = uw.op;

    // Condition select
    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_ACCEPT:   cond_hit = s_tvalid;
            C_FUNC:     cond_hit = stat.func;
            C_FILLGO:   cond_hit = stat.fill_go;
            C_FILLLAST: cond_hit = stat.fill_last;
            C_OUTFREE:  cond_hit = stat.out_free;
            default:    cond_hit = 1'b1;
        endcase
    end

    assign step_next = cond_hit ? uw.tgt_t : uw.tgt_f;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

`ifndef ASSERT_OFF
    // after an accepted beat the sequencer is busy before input ready returns
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted beat");

    // fill step is entered only from the parse step
    a_fill_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_FILL) && ($past(step_reg) != ST_FILL) |->
            $past(step_reg) == ST_PARSE)
        else $error("fill step entered from wrong step");
`endif

endmodule

// File: design/pgcb_dp.sv
// Datapath: list parser registers, fill buffer, terminal data and output stage.
module pgcb_dp
    import pgcb_pkg::*;
#(
    parameter int DATA_MAX = DATA_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tuser,
    input  logic [7:0]            s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser,
    input  dp_ctl_t               ctl,
    output dp_stat_t              stat
);

    localparam int AW = $clog2(DATA_MAX);
    localparam int CW = $clog2(DATA_MAX + 1);
    localparam int PW = $clog2(DATA_MAX + POS_DATA + 1);

    typedef enum logic [2:0] {
        PH_TAG1 = 3'b001,
        PH_TAG2 = 3'b010,
        PH_LEN  = 3'b100
    } phase_t;

    // Terminal data registers
    logic [31:0] txn_qual_reg;
    logic [47:0] amount_reg;
    logic [15:0] country_reg;
    logic [15:0] currency_reg;
    logic [23:0] txn_date_reg;
    logic [7:0]  txn_type_reg;
    logic [31:0] unpred_reg;

    // Parser and buffer control
    logic          func_reg;
    logic [7:0]    byte_reg;
    phase_t        phase_reg;
    logic [7:0]    tag1_reg;
    logic [7:0]    tag2_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic [PW-1:0] pos_reg;
    logic          reading_reg;
    logic [7:0]    remain_reg;
    logic [47:0]   fval_reg;

    // Buffer and output stage
    logic [7:0]    buf_mem [DATA_MAX];
    logic [7:0]    rd_data_reg;
    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;
    logic          m_tlast_reg;
    logic          m_tuser_reg;

    logic          out_free;
    logic          do_push;
    logic          buf_room;
    logic          do_emit;
    logic [47:0]   fval_sel;
    logic [PW-1:0] pos_eff;
    logic [AW-1:0] rd_addr;
    logic [7:0]    emit_byte;
    logic          emit_fin;
    logic [PW-1:0] data_end;

    assign out_free = !m_tvalid_reg || m_tready;
    assign do_push  = (ctl.op == OP_PUSH);
    assign buf_room = (cnt_reg < CW'(DATA_MAX));
    assign do_emit  = (ctl.op == OP_EMIT) && out_free;

    assign stat.func      = func_reg;
    assign stat.fill_go   = !reading_reg && (phase_reg == PH_LEN) && (byte_reg != 8'd0);
    assign stat.fill_last = (remain_reg == 8'd1);
    assign stat.out_free  = out_free;

    // Source for a length byte: matching terminal item, left aligned, else zeros
    always_comb begin
        priority if (tag1_reg == TAG_9F && tag2_reg == TAG2_TTQ && byte_reg == 8'd4) begin
            fval_sel = {txn_qual_reg, 16'd0};
        end else if (tag1_reg == TAG_9F && tag2_reg == TAG2_AMOUNT && byte_reg == 8'd6) begin
            fval_sel = amount_reg;
        end else if (tag1_reg == TAG_9F && tag2_reg == TAG2_COUNTRY && byte_reg == 8'd2) begin
            fval_sel = {country_reg, 32'd0};
        end else if (tag1_reg == TAG_5F && tag2_reg == TAG2_CURR && byte_reg == 8'd2) begin
            fval_sel = {currency_reg, 32'd0};
        end else if (tag1_reg == TAG_DATE && byte_reg == 8'd3) begin
            fval_sel = {txn_date_reg, 24'd0};
        end else if (tag1_reg == TAG_TYPE && byte_reg == 8'd1) begin
            fval_sel = {txn_type_reg, 40'd0};
        end else if (tag1_reg == TAG_9F && tag2_reg == TAG2_UN && byte_reg == 8'd4) begin
            fval_sel = {unpred_reg, 16'd0};
        end else begin
            fval_sel = 48'd0;
        end
    end

    // Read position: a fresh command starts at the header
    assign pos_eff  = reading_reg ? pos_reg : '0;
    assign rd_addr  = AW'(PW'(pos_eff - PW'(POS_DATA)));
    assign data_end = PW'(PW'(cnt_reg) + PW'(POS_DATA));

    // Command byte at the current position
    always_comb begin
        emit_fin = 1'b0;
        priority if (pos_reg == PW'(POS_CLA)) begin
            emit_byte = CMD_CLA;
        end else if (pos_reg == PW'(POS_INS)) begin
            emit_byte = CMD_INS;
        end else if (pos_reg == PW'(POS_P1) || pos_reg == PW'(POS_P2)) begin
            emit_byte = CMD_P1P2;
        end else if (pos_reg == PW'(POS_LC)) begin
            emit_byte = 8'(8'(cnt_reg) + 8'd2);
        end else if (pos_reg == PW'(POS_TMPL)) begin
            emit_byte = CMD_TEMPLATE;
        end else if (pos_reg == PW'(POS_LEN)) begin
            emit_byte = 8'(cnt_reg);
        end else if (pos_reg < data_end) begin
            emit_byte = rd_data_reg;
        end else begin
            emit_byte = CMD_LE;
            emit_fin  = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txn_qual_reg <= RST_TXN_QUAL;
            amount_reg   <= RST_AMOUNT;
            country_reg  <= RST_COUNTRY;
            currency_reg <= RST_CURRENCY;
            txn_date_reg <= RST_TXN_DATE;
            txn_type_reg <= RST_TXN_TYPE;
            unpred_reg   <= RST_UNPRED_NUM;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TXN_QUAL:   txn_qual_reg <= cfg_wr_data[31:0];
                REG_AMOUNT:     amount_reg   <= cfg_wr_data[47:0];
                REG_COUNTRY:    country_reg  <= cfg_wr_data[15:0];
                REG_CURRENCY:   currency_reg <= cfg_wr_data[15:0];
                REG_TXN_DATE:   txn_date_reg <= cfg_wr_data[23:0];
                REG_TXN_TYPE:   txn_type_reg <= cfg_wr_data[7:0];
                REG_UNPRED_NUM: unpred_reg   <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    // Parser, buffer bookkeeping and command stream control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TAG1;
            tag1_reg     <= '0;
            tag2_reg     <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            reading_reg  <= 1'b0;
            remain_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output beat: load on emit, drop once taken
            if (do_emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (ctl.op)
                OP_PARSE: begin
                    if (!reading_reg) begin
                        unique case (phase_reg)
                            PH_TAG1: begin
                                tag1_reg  <= byte_reg;
                                tag2_reg  <= '0;
                                phase_reg <= (byte_reg[4:0] == TAG_MULTI_MASK) ?
                                             PH_TAG2 : PH_LEN;
                            end
                            PH_TAG2: begin
                                tag2_reg  <= byte_reg;
                                phase_reg <= PH_LEN;
                            end
                            PH_LEN: begin
                                remain_reg <= byte_reg;
                                phase_reg  <= PH_TAG1;
                            end
                            default: phase_reg <= PH_TAG1;
                        endcase
                    end
                end
                OP_PUSH: begin
                    remain_reg <= remain_reg - 8'd1;
                    if (buf_room) begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_RDSET: begin
                    reading_reg <= 1'b1;
                    pos_reg     <= pos_eff;
                end
                OP_EMIT: begin
                    if (out_free) begin
                        if (emit_fin) begin
                            phase_reg   <= PH_TAG1;
                            tag1_reg    <= '0;
                            tag2_reg    <= '0;
                            cnt_reg     <= '0;
                            ovf_reg     <= 1'b0;
                            pos_reg     <= '0;
                            reading_reg <= 1'b0;
                        end else begin
                            pos_reg <= pos_reg + PW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            func_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
        if (ctl.op == OP_PARSE) begin
            fval_reg <= fval_sel;
        end else if (do_push) begin
            fval_reg <= {fval_reg[39:0], 8'd0};
        end
        if (do_emit) begin
            m_tdata_reg <= emit_byte;
            m_tlast_reg <= emit_fin;
            m_tuser_reg <= ovf_reg;
        end
    end

    // Fill buffer
    always_ff @(posedge aclk) begin
        if (do_push && buf_room) begin
            buf_mem[cnt_reg[AW-1:0]] <= fval_reg[47:40];
        end
        if (ctl.op == OP_RDSET) begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DATA_MAX))
        else $error("fill count beyond capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> cnt_reg == CW'(DATA_MAX))
        else $error("truncation flagged with room left");

    a_clear_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        do_emit && emit_fin |=> cnt_reg == '0 && !reading_reg && !ovf_reg)
        else $error("list not cleared after final byte");

    a_push_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |-> !reading_reg)
        else $error("buffer filled while streaming");
`endif

endmodule

// File: design/pdol_gpo_command_builder.sv
// A read beat passes the dispatch, read-setup and emit steps before it shows
// on m_tvalid (emit waits while the output is held); a tag byte passes dispatch
// and parse, and a length byte that fills L bytes goes on to the fill step, which
// pushes one buffer byte per cycle. A command of L data bytes takes L + 8 read beats.
// Reset: aresetn synchronous, active low; clears the list, the sequencer
// and the output stage and restores the terminal data registers.
module pdol_gpo_command_builder
    import pgcb_pkg::*;
#(
    parameter int DATA_MAX = DATA_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] list_byte
    input  logic                  s_tuser,   // [0] func
    // command beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] command_byte
    output logic                  m_tlast,   // final_byte
    output logic                  m_tuser    // [0] data_truncated
);

    dp_ctl_t  ctl;
    dp_stat_t stat;

    pgcb_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    pgcb_dp #(
        .DATA_MAX (DATA_MAX)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .ctl         (ctl),
        .stat        (stat)
    );

endmodule
